>>> design/nibble_crc32_store_check_top_macros.svh
// Assertion macros shared by the store check block.
`ifndef NIBBLE_CRC32_STORE_CHECK_TOP_MACROS_SVH
`define NIBBLE_CRC32_STORE_CHECK_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define NCRC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ncrc assertion failed");

// Next-cycle implication, disabled while reset is held.
`define NCRC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ncrc assertion failed");

`endif

>>> design/ncrc_pkg.sv
// Package with types, constants and the nibble step of the store check block.
package ncrc_pkg;

    localparam int HEADER_BYTES = 4;
    localparam int POS_W = 3;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [POS_W-1:0] HEADER_POS = POS_W'(HEADER_BYTES);

    // Reflected CRC-32 table for polynomial 0xEDB88320, one entry per nibble.
    localparam logic [31:0] NIB_TAB [16] = '{
        32'h00000000, 32'h1db71064, 32'h3b6e20c8, 32'h26d930ac,
        32'h76dc4190, 32'h6b6b51f4, 32'h4db26158, 32'h5005713c,
        32'hedb88320, 32'hf00f9344, 32'hd6d6a3e8, 32'hcb61b38c,
        32'h9b64c2b0, 32'h86d3d2d4, 32'ha00ae278, 32'hbdbdf21c
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] computed_crc;
        logic [31:0] stored_crc;
        logic        crc_match;
    } result_t;

    function automatic logic [31:0] nib_step(input logic [31:0] c, input logic [3:0] nib);
        logic [3:0] idx;
        idx = c[3:0] ^ nib;
        return NIB_TAB[idx] ^ (c >> 4);
    endfunction

endpackage

>>> design/ncrc_in_stage.sv
// Input register that holds one word until the core takes it.
module ncrc_in_stage
    import ncrc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     consume,
    output logic     in_valid,
    output in_item_t in_item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_ready  = !valid_reg || consume;
    assign in_valid = valid_reg;
    assign in_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (consume) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

>>> design/ncrc_core.sv
// Header collection and CRC update for one byte per cycle; a final byte waits while the result slot is full.
module ncrc_core
    import ncrc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    input  in_item_t in_item,
    input  logic     out_free,
    output logic     consume,
    output logic     res_valid,
    output result_t  res
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [31:0]      hdr_reg;
    logic [31:0]      hdr_next;
    logic [31:0]      crc_reg;
    logic [31:0]      crc_next;
    logic [31:0]      hdr_upd;
    logic [31:0]      crc_upd;
    logic [31:0]      crc_mid;

    // A word without the final flag never needs the result slot.
    assign consume   = in_valid && (!in_item.last_byte || out_free);
    assign res_valid = consume && in_item.last_byte;

    always_comb begin
        hdr_upd = hdr_reg;
        crc_upd = crc_reg;
        crc_mid = nib_step(crc_reg, in_item.data_byte[3:0]);
        pos_next = pos_reg;
        if (pos_reg < HEADER_POS) begin
            hdr_upd  = {hdr_reg[23:0], in_item.data_byte};
            pos_next = pos_reg + POS_W'(1);
        end else begin
            crc_upd = ~nib_step(crc_mid, in_item.data_byte[7:4]);
        end
        hdr_next = hdr_upd;
        crc_next = crc_upd;
        if (in_item.last_byte) begin
            pos_next = '0;
            hdr_next = '0;
            crc_next = CRC_INIT;
        end
    end

    assign res.computed_crc = crc_upd;
    assign res.stored_crc   = hdr_upd;
    assign res.crc_match    = (crc_upd == hdr_upd);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            hdr_reg <= '0;
            crc_reg <= CRC_INIT;
        end else if (consume) begin
            pos_reg <= pos_next;
            hdr_reg <= hdr_next;
            crc_reg <= crc_next;
        end
    end

endmodule

>>> design/ncrc_out_stage.sv
// Result register that holds one result word until the receiver takes it.
module ncrc_out_stage
    import ncrc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    res_valid,
    input  result_t res,
    output logic    out_free,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (res_valid) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

endmodule

>>> design/nibble_crc32_store_check_top.sv
// Top level of the store CRC check: stream in of store bytes, stream out of results.
//
// The slave channel takes one store byte per word, in address order, with tlast
// on the final byte. The first four bytes form the stored CRC, most significant
// byte first; every later byte updates a reflected CRC-32 through two nibble
// table steps and the running value is complemented after each byte.
// The master channel gives one word per store, on its final byte: the computed
// CRC, the stored CRC and a match flag.
// A byte is taken into an input register, processed from there and the result lands
// in an output register, so a result word passes through both registers after its
// final byte is accepted. One byte per cycle is sustained while no final byte waits
// on a pending result; the CRC loop runs through both nibble steps combinationally.
// When the receiver stalls, the output register holds its word and data bytes
// keep flowing; only a second final byte waits until the pending result is taken.
// Synchronous active-low reset empties both registers and restarts the pass.
module nibble_crc32_store_check_top
    import ncrc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] data_byte
    input  logic        s_tlast,  // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // [31:0] computed_crc, [63:32] stored_crc
    output logic [0:0]  m_tuser   // [0] crc_match
);

    `include "nibble_crc32_store_check_top_macros.svh"

    in_item_t s_item;
    in_item_t in_item;
    logic     in_valid;
    logic     consume;
    logic     res_valid;
    logic     out_free;
    result_t  res;
    result_t  m_res;

    assign s_item.data_byte = s_tdata;
    assign s_item.last_byte = s_tlast;

    ncrc_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_item   (s_item),
        .consume  (consume),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    ncrc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .out_free  (out_free),
        .consume   (consume),
        .res_valid (res_valid),
        .res       (res)
    );

    ncrc_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (m_res)
    );

    assign m_tdata    = {m_res.stored_crc, m_res.computed_crc};
    assign m_tuser[0] = m_res.crc_match;

    // The input side only stalls while a word is held and cannot move on.
    `NCRC_ASSERT_IMPL(a_stall_only_when_held, aclk, aresetn, !s_tready, in_valid && !consume)
    // A new result never overwrites one that the receiver has not taken.
    `NCRC_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, res_valid, !m_tvalid || m_tready)
    // The match flag agrees with the two CRC fields of the result word.
    `NCRC_ASSERT_IMPL(a_match_consistent, aclk, aresetn, m_tvalid,
        m_tuser[0] == (m_tdata[31:0] == m_tdata[63:32]))
    // A processed final byte always leaves a result waiting in the next cycle.
    `NCRC_ASSERT_NEXT(a_result_follows, aclk, aresetn, res_valid, m_tvalid)

endmodule
